FILE: rtl/adpcm_nd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nd_pkg
// Types, codes and tables shared by the 4-bit ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package adpcm_nd_pkg;

    localparam int STEP_COUNT = 49;
    localparam int IDX_W      = 6;
    localparam int STEP_W     = 11;
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 17;
    localparam int COUNT_W    = 20;
    localparam int CFG_W      = 12;
    localparam int CHAN_W     = 9;
    localparam int PROD1_W    = 21;
    localparam int PROD2_W    = 34;
    localparam int LEVEL_SHIFT = 14;

    localparam logic [IDX_W-1:0]   IDX_MAX      = IDX_W'(STEP_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 20'h80000;
    localparam logic [CFG_W-1:0]   CHIP_VOL_RST = 12'd1024;
    localparam logic [CHAN_W-1:0]  CHAN_VOL_RST = 9'd64;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // configuration register indexes
    localparam logic CFG_CHIP_VOLUME = 1'b0;
    localparam logic CFG_CHAN_VOLUME = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECODE,
        ST_MUL1,
        ST_MUL2,
        ST_SCALE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic load_in;    // capture an accepted input beat
        logic kill;       // end playback, no result
        logic decode;     // decode the selected nibble
        logic mul1;       // sample times channel gain
        logic mul2;       // times chip gain
        logic scale;      // divide, saturate, load result register
        logic low_nibble; // nibble select
    } t_dp_cmd;

    typedef struct packed {
        logic can_decode;
        logic playing;
    } t_dp_stat;

    // step sizes: floor(1.1^i * 16)
    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        unique case (idx)
            6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        unique case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/adpcm_nd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nd_ctrl
// Sequencer: accepts beats, steps each nibble through decode and scaling.
// ----------------------------------------------------------------------------
module adpcm_nd_ctrl
    import adpcm_nd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_kind,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_low, n_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        o_cmd       = '0;
        o_cmd.low_nibble = r_low;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_kind == KIND_DATA) begin
                        n_low   = 1'b0;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // drop the byte when nothing is left to play
                if (i_stat.can_decode) begin
                    n_state = ST_DECODE;
                end else begin
                    o_cmd.kill = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (!r_low && i_stat.playing) begin
                        n_low   = 1'b1;
                        n_state = ST_DECODE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/adpcm_nd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nd_dp
// Datapath: decoder state, gain registers, two multiplies and the result.
// ----------------------------------------------------------------------------
module adpcm_nd_dp
    import adpcm_nd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_kind,
    input  logic [COUNT_W-1:0]         i_nibble_count,
    input  logic [7:0]                 i_data_byte,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic signed [LEVEL_W-1:0]  o_level,
    output logic                       o_last,
    output logic                       o_playing
);

    logic [CFG_W-1:0]           r_chip_vol;
    logic [CHAN_W-1:0]          r_chan_vol;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [IDX_W-1:0]           r_index;
    logic [COUNT_W-1:0]         r_left;
    logic                       r_active;
    logic [7:0]                 r_byte;
    logic signed [PROD1_W-1:0]  r_prod1;
    logic signed [PROD2_W-1:0]  r_prod2;

    logic [3:0]                 w_code;
    logic [STEP_W-1:0]          w_step;
    logic [SAMPLE_W-1:0]        w_delta;
    logic signed [13:0]         w_sum;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic signed [7:0]          w_idx_sum;
    logic [IDX_W-1:0]           n_index;
    logic signed [PROD1_W-1:0]  n_prod1;
    logic signed [PROD2_W-1:0]  n_prod2;
    logic signed [PROD2_W-1:0]  w_biased;
    logic signed [19:0]         w_quot;
    logic signed [LEVEL_W-1:0]  n_level;
    logic signed [4:0]          w_move;

    // nibble decode
    always_comb begin
        w_code  = i_cmd.low_nibble ? r_byte[3:0] : r_byte[7:4];
        w_step  = step_size(r_index);
        w_delta = SAMPLE_W'(w_step >> 3)
                + (w_code[0] ? SAMPLE_W'(w_step >> 2) : '0)
                + (w_code[1] ? SAMPLE_W'(w_step >> 1) : '0)
                + (w_code[2] ? SAMPLE_W'(w_step) : '0);
        if (w_code[3]) begin
            w_sum = {{2{r_sample[SAMPLE_W-1]}}, r_sample} - $signed({2'b00, w_delta});
        end else begin
            w_sum = {{2{r_sample[SAMPLE_W-1]}}, r_sample} + $signed({2'b00, w_delta});
        end
        priority if (w_sum > 14'sd2047) begin
            n_sample = 12'sd2047;
        end else if (w_sum < -14'sd2048) begin
            n_sample = -12'sd2048;
        end else begin
            n_sample = w_sum[SAMPLE_W-1:0];
        end
        w_move    = index_move(w_code[2:0]);
        w_idx_sum = $signed({2'b00, r_index}) + $signed({{3{w_move[4]}}, w_move});
        priority if (w_idx_sum < 8'sd0) begin
            n_index = '0;
        end else if (w_idx_sum > $signed({2'b00, IDX_MAX})) begin
            n_index = IDX_MAX;
        end else begin
            n_index = w_idx_sum[IDX_W-1:0];
        end
    end

    // gain and truncating divide by 2^14
    always_comb begin
        n_prod1  = r_sample * $signed({1'b0, r_chan_vol});
        n_prod2  = r_prod1 * $signed({1'b0, r_chip_vol});
        w_biased = r_prod2 + (r_prod2[PROD2_W-1] ? PROD2_W'((1 << LEVEL_SHIFT) - 1) : '0);
        w_quot   = w_biased[PROD2_W-1:LEVEL_SHIFT];
        priority if (w_quot > 20'sd65535) begin
            n_level = 17'sd65535;
        end else if (w_quot < -20'sd65536) begin
            n_level = -17'sd65536;
        end else begin
            n_level = w_quot[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_vol <= CHIP_VOL_RST;
            r_chan_vol <= CHAN_VOL_RST;
            r_sample   <= '0;
            r_index    <= '0;
            r_left     <= '0;
            r_active   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHIP_VOLUME: r_chip_vol <= i_cfg_data;
                    CFG_CHAN_VOLUME: r_chan_vol <= i_cfg_data[CHAN_W-1:0];
                endcase
            end
            if (i_cmd.load_in && i_kind == KIND_START && i_nibble_count < COUNT_LIMIT) begin
                r_sample <= '0;
                r_index  <= '0;
                r_left   <= i_nibble_count;
                r_active <= (i_nibble_count != '0);
            end
            if (i_cmd.kill) begin
                r_active <= 1'b0;
            end
            if (i_cmd.decode) begin
                r_sample <= n_sample;
                r_index  <= n_index;
                r_left   <= r_left - 1'b1;
                r_active <= (r_left != COUNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= n_prod1;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= n_prod2;
        end
        if (i_cmd.scale) begin
            o_sample  <= r_sample;
            o_level   <= n_level;
            o_last    <= i_cmd.low_nibble | ~r_active;
            o_playing <= r_active;
        end
    end

    assign o_stat.can_decode = r_active && (r_left != '0);
    assign o_stat.playing    = r_active;

endmodule

FILE: rtl/adpcm_nibble_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder_unit
// 4-bit ADPCM decoder: start beats arm playback, data beats give up to two
// samples (high nibble first), each with a gain-scaled level.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       i_in_valid / o_in_ready   i_kind, i_nibble_count, i_data_byte
//  out      o_out_valid / i_out_ready o_sample, o_level, o_last, o_playing
//  cfg      i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
//  A data beat is checked first; each decoded nibble then steps through
//  decode, two chained gain multiplies and scale, then the out beat.
//  Input is taken only when the sequencer is idle; a stalled out beat
//  holds everything. Reset is synchronous, low active, and restores the
//  gains to 1024 and 64 and stops playback.
// ----------------------------------------------------------------------------
module adpcm_nibble_decoder_unit
    import adpcm_nd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_kind,
    input  logic [COUNT_W-1:0]         i_nibble_count,
    input  logic [7:0]                 i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic signed [LEVEL_W-1:0]  o_level,
    output logic                       o_last,
    output logic                       o_playing,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: owns the handshakes, issues at most one command per cycle
    adpcm_nd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: decoder state, gains, multiplies, result register
    adpcm_nd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_nibble_count (i_nibble_count),
        .i_data_byte    (i_data_byte),
        .o_sample       (o_sample),
        .o_level        (o_level),
        .o_last         (o_last),
        .o_playing      (o_playing)
    );

    // never take input while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while result pending");

    // a result that is not the byte's last keeps playback going
    a_first_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_playing)
        else $error("non-final result without playback");

    // after a non-final beat the second nibble follows before new input
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> !o_in_ready)
        else $error("low nibble skipped");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4-bit ADPCM nibble decoder. A behavioral model
// of the decoder predicts each sample, level, last and playing flag from the
// accepted input beats. A monitor matches every output beat against the
// oldest prediction. Directed checks come first: ignored starts, data while
// idle, a count that ends in the middle of a byte, restart, saturation and
// level overflow. Random playback sequences follow under several gain
// settings, with random gaps on the input, random stalls on the output and
// one long output hold.
// ----------------------------------------------------------------------------
module tb;
    import adpcm_nd_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 32;
    localparam int LONG_HOLD_CYCLES = 400;

    // one decoded nibble as it should leave the block
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [LEVEL_W-1:0]  level;
        logic                       last;
        logic                       playing;
    } t_pcm_result;

    // output ready patterns
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TWO_OF_THREE} t_sink_mode;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic                       in_kind   = KIND_START;
    logic [COUNT_W-1:0]         in_count  = '0;
    logic [7:0]                 in_byte   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic signed [LEVEL_W-1:0]  out_level;
    logic                       out_last;
    logic                       out_playing;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = CFG_CHIP_VOLUME;
    logic [CFG_W-1:0]           cfg_data  = '0;

    adpcm_nibble_decoder_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (in_kind),
        .i_nibble_count (in_count),
        .i_data_byte    (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_sample       (out_sample),
        .o_level        (out_level),
        .o_last         (out_last),
        .o_playing      (out_playing),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------------
    int                 step_lut [0:STEP_COUNT-1];
    int                 pb_sample;
    int                 pb_index;
    logic [COUNT_W-1:0] pb_left;
    bit                 pb_active;
    int                 pb_chip;
    int                 pb_chan;

    t_pcm_result pending_pcm [$];
    int          errors       = 0;
    int          useful_beats = 0;
    int          cycle_count  = 0;

    // sender burst control
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // receiver stall control
    t_sink_mode sink_mode  = SINK_OPEN;
    int         sink_left  = 0;
    int         sink_phase = 0;
    bit         long_hold  = 1'b0;
    event       long_hold_ev;

    // Decode one code against the model state and advance it.
    function automatic int decode_code(input logic [3:0] code);
        int step;
        int delta;
        int acc;
        int idx;
        step  = step_lut[pb_index];
        delta = step >>> 3;
        if (code[0]) delta += step >>> 2;
        if (code[1]) delta += step >>> 1;
        if (code[2]) delta += step;
        if (code[3]) delta = -delta;
        acc = pb_sample + delta;
        if (acc > 2047) acc = 2047;
        if (acc < -2048) acc = -2048;
        pb_sample = acc;
        // small magnitudes back off by one, large ones jump by 2, 4, 6, 8
        idx = code[2] ? pb_index + 2 * (int'(code[1:0]) + 1) : pb_index - 1;
        if (idx > STEP_COUNT - 1) idx = STEP_COUNT - 1;
        if (idx < 0) idx = 0;
        pb_index = idx;
        return acc;
    endfunction

    // Apply both gains, truncate toward zero, clamp to the level range.
    function automatic int scale_gain(input int s);
        longint p;
        p = longint'(s) * longint'(pb_chan) * longint'(pb_chip);
        p = p / 16384;
        if (p > 65535) p = 65535;
        if (p < -65536) p = -65536;
        return int'(p);
    endfunction

    // Update the model for one accepted input beat and queue its results.
    function automatic void predict_beat(input logic k, input logic [COUNT_W-1:0] cnt,
                                         input logic [7:0] b);
        t_pcm_result r [0:1];
        int          n;
        int          s;
        logic [3:0]  code;
        n = 0;
        if (k == KIND_START) begin
            // counts at or above the limit leave everything untouched
            if (cnt < COUNT_LIMIT) begin
                pb_sample = 0;
                pb_index  = 0;
                pb_left   = cnt;
                pb_active = (cnt != '0);
                useful_beats++;
            end
        end else begin
            for (int half = 0; half < 2; half++) begin
                code = (half == 0) ? b[7:4] : b[3:0];
                if (!pb_active || pb_left == '0) begin
                    pb_active = 1'b0;
                end else begin
                    s = decode_code(code);
                    pb_left--;
                    if (pb_left == '0) pb_active = 1'b0;
                    r[n].sample  = SAMPLE_W'(s);
                    r[n].level   = LEVEL_W'(scale_gain(s));
                    r[n].last    = 1'b0;
                    r[n].playing = pb_active;
                    n++;
                end
            end
            if (n > 0) begin
                r[n-1].last = 1'b1;
                useful_beats++;
            end
            for (int j = 0; j < n; j++) pending_pcm.push_back(r[j]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output monitor: match each out beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : pcm_monitor
        t_pcm_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pcm.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: sample %0d level %0d last %0b playing %0b",
                         $time, out_sample, out_level, out_last, out_playing);
            end else begin
                want = pending_pcm.pop_front();
                if (out_sample !== want.sample || out_level !== want.level ||
                    out_last !== want.last || out_playing !== want.playing) begin
                    errors++;
                    if (out_sample !== want.sample)
                        $display("%0t: sample expected %0d actual %0d",
                                 $time, want.sample, out_sample);
                    if (out_level !== want.level)
                        $display("%0t: level expected %0d actual %0d",
                                 $time, want.level, out_level);
                    if (out_last !== want.last)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, out_last);
                    if (out_playing !== want.playing)
                        $display("%0t: playing expected %0b actual %0b",
                                 $time, want.playing, out_playing);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch between stall patterns; drop ready during a long hold
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : sink_pattern
        logic ready_next;
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 96);
        end
        sink_left--;
        sink_phase++;
        case (sink_mode)
            SINK_OPEN:   ready_next = 1'b1;
            SINK_COIN:   ready_next = 1'($urandom_range(0, 1));
            SINK_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
            default:     ready_next = (sink_phase % 3) != 0;
        endcase
        out_ready = ready_next && !long_hold;
    end

    // Hold the output off for a fixed stretch when asked.
    always begin
        @(long_hold_ev);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Offer one beat, hold it until taken, then predict its results.
    task automatic send_beat(input logic k, input logic [COUNT_W-1:0] cnt,
                             input logic [7:0] b);
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge clk);
                in_valid = 1'b0;
                in_kind  = 1'($urandom);
                in_count = COUNT_W'($urandom);
                in_byte  = 8'($urandom);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        in_kind  = k;
        in_count = cnt;
        in_byte  = b;
        do @(posedge clk); while (!in_ready);
        predict_beat(k, cnt, b);
    endtask

    // Drop valid, wait for every result, then let the block go quiet.
    task automatic settle_block();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pcm.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one gain register while the block is idle.
    task automatic write_gain(input logic idx, input int value);
        settle_block();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_data  = CFG_W'($urandom);
        if (idx == CFG_CHIP_VOLUME) pb_chip = value & 'hFFF;
        else pb_chan = value & 'h1FF;
    endtask

    // One random stretch of traffic: mostly a start followed by about the
    // right number of data bytes, sometimes noise or a cut-short sequence.
    task automatic play_random_sequence();
        int                 pick;
        int                 nbytes;
        logic [COUNT_W-1:0] cnt;
        pick    = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 3) != 0);
        if (pick < 10) begin
            send_beat(1'($urandom), COUNT_W'($urandom), 8'($urandom));
        end else begin
            if (pick < 15) cnt = COUNT_W'($urandom);
            else if (pick < 19) cnt = '0;
            else cnt = COUNT_W'($urandom_range(1, 40));
            send_beat(KIND_START, cnt, 8'($urandom));
            if (cnt <= 80) nbytes = (int'(cnt) + 1) / 2 + $urandom_range(0, 1);
            else nbytes = $urandom_range(1, 8);
            // broken sequence: the next start cuts playback short
            if ($urandom_range(0, 9) == 0) nbytes = nbytes / 2;
            repeat (nbytes) send_beat(KIND_DATA, COUNT_W'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Starts at or above the count limit, a zero count, and data while idle.
    task automatic test_ignored_beats();
        send_beat(KIND_START, COUNT_LIMIT, 8'($urandom));
        send_beat(KIND_DATA, COUNT_W'($urandom), 8'hA5);
        send_beat(KIND_START, 20'hFFFFF, 8'($urandom));
        send_beat(KIND_DATA, COUNT_W'($urandom), 8'h5A);
        send_beat(KIND_START, '0, 8'($urandom));
        send_beat(KIND_DATA, COUNT_W'($urandom), 8'hFF);
    endtask

    // Short playback ending mid-byte, data after the end, restart mid-play.
    task automatic test_basic_playback();
        send_beat(KIND_START, 20'd3, 8'h00);
        send_beat(KIND_DATA, 20'h00000, 8'h07);
        send_beat(KIND_DATA, 20'hFFFFF, 8'hF8);
        send_beat(KIND_DATA, 20'h12345, 8'h11);
        send_beat(KIND_START, 20'd5, 8'hFF);
        send_beat(KIND_DATA, 20'h80000, 8'h4C);
        send_beat(KIND_START, 20'd2, 8'h00);
        send_beat(KIND_DATA, 20'h7FFFF, 8'h93);
    endtask

    // Drive the sample into both rails at maximum gains so the level clamps.
    task automatic test_saturation();
        write_gain(CFG_CHIP_VOLUME, 4095);
        write_gain(CFG_CHAN_VOLUME, 511);
        send_beat(KIND_START, 20'h7FFFF, 8'($urandom));
        repeat (4) send_beat(KIND_DATA, COUNT_W'($urandom), 8'h77);
        repeat (3) send_beat(KIND_DATA, COUNT_W'($urandom), 8'hFF);
    endtask

    // Random traffic under one gain setting.
    task automatic test_random_traffic(input int chip, input int chan, input int beats);
        int target;
        write_gain(CFG_CHIP_VOLUME, chip);
        write_gain(CFG_CHAN_VOLUME, chan);
        target = useful_beats + beats;
        while (useful_beats < target) play_random_sequence();
    endtask

    // Hold the output off while the sender keeps offering beats.
    task automatic test_backpressure(input int beats);
        int target;
        target = useful_beats + beats;
        -> long_hold_ev;
        gaps_on = 1'b0;
        while (useful_beats < target) play_random_sequence();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        step_lut = '{
            16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
            73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
            337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963, 1060, 1166, 1282,
            1411, 1552};
        pb_sample = 0;
        pb_index  = 0;
        pb_left   = '0;
        pb_active = 1'b0;
        pb_chip   = int'(CHIP_VOL_RST);
        pb_chan   = int'(CHAN_VOL_RST);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_ignored_beats();
        test_basic_playback();
        test_saturation();
        test_random_traffic(0, 0, 300);
        test_random_traffic(2048, 256, 300);
        test_backpressure(60);
        test_random_traffic(1024, 64, 300);
        test_random_traffic($urandom_range(0, 4095), $urandom_range(0, 4095), 300);

        settle_block();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
